// ----- sv/iougbt_pkg.sv -----
package iougbt_pkg;

   // fixed field widths
   localparam int CoordBits = 12;
   localparam int SizeBits  = 13;
   localparam int IdBits    = 16;
   localparam int AreaBits  = 24;
   localparam int UnionBits = 25;
   localparam int ThrBits   = 8;
   localparam int CsrBits   = 13;
   localparam int EntryBits = IdBits + 4 * CoordBits;

   // configuration register indexes
   localparam logic [1:0] CsrThreshold   = 2'd0;
   localparam logic [1:0] CsrFrameWidth  = 2'd1;
   localparam logic [1:0] CsrFrameHeight = 2'd2;

   localparam logic [IdBits-1:0] IdFirst = 16'd1;
   localparam logic [IdBits-1:0] IdLast  = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   // one stored track: ID and box
   typedef struct packed {
      logic [IdBits-1:0]    id;
      logic [CoordBits-1:0] x;
      logic [CoordBits-1:0] y;
      logic [CoordBits-1:0] w;
      logic [CoordBits-1:0] h;
   } entry_type;

endpackage

// ----- sv/iou_greedy_box_tracker.sv -----
// Channel   | Handshake            | Carries
// req_      | req_valid/req_ready  | has_box, box_x/y/w/h, frame_last
// rsp_      | rsp_valid/rsp_ready  | track_id, is_new_track, clip_*, visible, stored, result_last
// csr_      | csr_we (no wait)     | csr_addr, csr_wdata
// A box request reads the tracks kept from the previous frame one by one, passes the
// reads through three compute stages, checks that those stages have drained, then
// writes the entry, if there is room, and the result. A marker request gives no result.
// Both tables share one RAM, two banks that swap at frame end, so reset needs no
// clearing pass. A new request is taken while a result still waits;
// the result cycle holds until rsp is free.
module iou_greedy_box_tracker #(
   parameter int MAX_TRACKS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_has_box,
   input  logic [iougbt_pkg::CoordBits-1:0]    req_box_x,
   input  logic [iougbt_pkg::CoordBits-1:0]    req_box_y,
   input  logic [iougbt_pkg::CoordBits-1:0]    req_box_w,
   input  logic [iougbt_pkg::CoordBits-1:0]    req_box_h,
   input  logic                                req_frame_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [iougbt_pkg::IdBits-1:0]       rsp_track_id,
   output logic                                rsp_is_new_track,
   output logic [iougbt_pkg::CoordBits-1:0]    rsp_clip_x,
   output logic [iougbt_pkg::CoordBits-1:0]    rsp_clip_y,
   output logic [iougbt_pkg::SizeBits-1:0]     rsp_clip_w,
   output logic [iougbt_pkg::SizeBits-1:0]     rsp_clip_h,
   output logic                                rsp_visible,
   output logic                                rsp_stored,
   output logic                                rsp_result_last,
   input  logic                                csr_we,
   input  logic [1:0]                          csr_addr,
   input  logic [iougbt_pkg::CsrBits-1:0]      csr_wdata
);

   import iougbt_pkg::*;

   localparam int IdxW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int CntW  = $clog2(MAX_TRACKS + 1);
   localparam int AddrW = IdxW + 1;
   localparam int RamDepth = 2 << IdxW;
   localparam logic [CntW-1:0] CntMax = CntW'(MAX_TRACKS);
   localparam int CrossBits = AreaBits + UnionBits;

   // control state
   state_type            state_ff, state_in;
   logic                 prev_bank_ff, prev_bank_in;
   logic [CntW-1:0]      prev_count_ff, prev_count_in;
   logic [CntW-1:0]      new_count_ff, new_count_in;
   logic [CntW-1:0]      idx_ff, idx_in;
   logic [MAX_TRACKS-1:0] used_ff, used_in;
   logic [IdBits-1:0]    next_id_ff, next_id_in;
   logic                 v0_ff, v1_ff, v2_ff;
   logic                 best_found_ff, best_found_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [ThrBits-1:0]   thr_ff;
   logic [SizeBits-1:0]  fw_ff, fh_ff;

   // request payload
   logic [CoordBits-1:0] bx_ff, by_ff, bw_ff, bh_ff;
   logic                 last_ff;
   logic [AreaBits-1:0]  area_a_ff;

   // scan pipeline payload
   logic [IdxW-1:0]      ix0_ff, ix1_ff, ix2_ff;
   logic                 ok1_ff, ok2_ff;
   logic [AreaBits-1:0]  o1_ff, at1_ff, o2_ff;
   logic [UnionBits-1:0] u2_ff;
   logic [IdBits-1:0]    id1_ff, id2_ff;
   logic [IdxW-1:0]      best_ix_ff;
   logic [IdBits-1:0]    best_id_ff;
   logic [AreaBits-1:0]  best_o_ff;
   logic [UnionBits-1:0] best_u_ff;

   // result registers
   logic [IdBits-1:0]    r_id_ff;
   logic                 r_new_ff, r_vis_ff, r_stored_ff, r_last_ff;
   logic [CoordBits-1:0] r_x_ff, r_y_ff;
   logic [SizeBits-1:0]  r_w_ff, r_h_ff;

   logic                 req_take, rd_en, scan_done, out_free, finish_go;
   logic                 wr_en;
   logic [AddrW-1:0]     rd_addr, wr_addr;
   logic [EntryBits-1:0] rd_word;
   entry_type            rd_entry, wr_entry;

   assign req_take  = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rd_en     = (state_ff == ST_SCAN) && (idx_ff < prev_count_ff);
   assign scan_done = (state_ff == ST_SCAN) && !rd_en && !v0_ff && !v1_ff && !v2_ff;
   assign finish_go = (state_ff == ST_FINISH) && out_free;
   assign rd_addr   = {prev_bank_ff, idx_ff[IdxW-1:0]};
   assign wr_addr   = {!prev_bank_ff, new_count_ff[IdxW-1:0]};
   assign wr_en     = finish_go && (new_count_ff < CntMax);
   assign rd_entry  = entry_type'(rd_word);

   // track table, both banks
   iougbt_ram #(
      .Width(EntryBits),
      .Depth(RamDepth)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_word)
   );

   // stage 1: overlap extents and areas
   logic [SizeBits-1:0]  s1_x1, s1_y1, s1_x2, s1_y2, s1_ae, s1_te;
   logic [SizeBits-1:0]  s1_dx, s1_dy;
   logic                 s1_ok;
   always_comb begin
      s1_x1 = (bx_ff > rd_entry.x) ? {1'b0, bx_ff} : {1'b0, rd_entry.x};
      s1_y1 = (by_ff > rd_entry.y) ? {1'b0, by_ff} : {1'b0, rd_entry.y};
      s1_ae = {1'b0, bx_ff} + {1'b0, bw_ff};
      s1_te = {1'b0, rd_entry.x} + {1'b0, rd_entry.w};
      s1_x2 = (s1_ae < s1_te) ? s1_ae : s1_te;
      s1_ae = {1'b0, by_ff} + {1'b0, bh_ff};
      s1_te = {1'b0, rd_entry.y} + {1'b0, rd_entry.h};
      s1_y2 = (s1_ae < s1_te) ? s1_ae : s1_te;
      s1_dx = s1_x2 - s1_x1;
      s1_dy = s1_y2 - s1_y1;
      s1_ok = !used_ff[ix0_ff] && (s1_x2 > s1_x1) && (s1_y2 > s1_y1);
   end

   // stage 3: threshold test and best compare
   logic [CrossBits-1:0] s3_l, s3_r;
   logic [UnionBits+ThrBits-1:0] s3_thr_u, s3_o_sh;
   logic                 s3_take;
   always_comb begin
      s3_thr_u = thr_ff * u2_ff;
      s3_o_sh  = (UnionBits+ThrBits)'({o2_ff, 8'd0});
      s3_l     = o2_ff * best_u_ff;
      s3_r     = best_o_ff * u2_ff;
      s3_take  = v2_ff && ok2_ff && (s3_o_sh > s3_thr_u) &&
                 (!best_found_ff || (s3_l > s3_r) ||
                  ((s3_l == s3_r) && (id2_ff < best_id_ff)));
   end

   // result fields
   logic [IdBits-1:0]    f_id;
   logic                 f_vis;
   logic [SizeBits-1:0]  f_xe, f_ye, f_w, f_h;
   always_comb begin
      f_id  = best_found_ff ? best_id_ff : next_id_ff;
      f_vis = (bw_ff != '0) && (bh_ff != '0) &&
              ({1'b0, bx_ff} < fw_ff) && ({1'b0, by_ff} < fh_ff);
      f_xe  = {1'b0, bx_ff} + {1'b0, bw_ff};
      f_ye  = {1'b0, by_ff} + {1'b0, bh_ff};
      f_w   = ((f_xe < fw_ff) ? f_xe : fw_ff) - {1'b0, bx_ff};
      f_h   = ((f_ye < fh_ff) ? f_ye : fh_ff) - {1'b0, by_ff};
      wr_entry = '{id: f_id, x: bx_ff, y: by_ff, w: bw_ff, h: bh_ff};
   end

   // next control state
   always_comb begin
      state_in      = state_ff;
      prev_bank_in  = prev_bank_ff;
      prev_count_in = prev_count_ff;
      new_count_in  = new_count_ff;
      idx_in        = idx_ff;
      used_in       = used_ff;
      next_id_in    = next_id_ff;
      best_found_in = best_found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_has_box) begin
                  state_in      = ST_SCAN;
                  idx_in        = '0;
                  best_found_in = 1'b0;
               end else if (req_frame_last) begin
                  prev_bank_in  = !prev_bank_ff;
                  prev_count_in = new_count_ff;
                  new_count_in  = '0;
                  used_in       = '0;
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               idx_in = idx_ff + 1'b1;
            end
            if (s3_take) begin
               best_found_in = 1'b1;
            end
            if (scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_go) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (best_found_ff) begin
                  used_in[best_ix_ff] = 1'b1;
               end else begin
                  next_id_in = (next_id_ff == IdLast) ? IdFirst : next_id_ff + 1'b1;
               end
               if (wr_en) begin
                  new_count_in = new_count_ff + 1'b1;
               end
               if (last_ff) begin
                  prev_bank_in  = !prev_bank_ff;
                  prev_count_in = wr_en ? new_count_ff + 1'b1 : new_count_ff;
                  new_count_in  = '0;
                  used_in       = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         prev_bank_ff  <= 1'b0;
         prev_count_ff <= '0;
         new_count_ff  <= '0;
         idx_ff        <= '0;
         used_ff       <= '0;
         next_id_ff    <= IdFirst;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         v0_ff         <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         thr_ff        <= 8'd51;
         fw_ff         <= 13'd1920;
         fh_ff         <= 13'd1080;
      end else begin
         state_ff      <= state_in;
         prev_bank_ff  <= prev_bank_in;
         prev_count_ff <= prev_count_in;
         new_count_ff  <= new_count_in;
         idx_ff        <= idx_in;
         used_ff       <= used_in;
         next_id_ff    <= next_id_in;
         best_found_ff <= best_found_in;
         rsp_valid_ff  <= rsp_valid_in;
         v0_ff         <= rd_en;
         v1_ff         <= v0_ff;
         v2_ff         <= v1_ff;
         if (csr_we) begin
            case (csr_addr)
               CsrThreshold:   thr_ff <= csr_wdata[ThrBits-1:0];
               CsrFrameWidth:  fw_ff  <= csr_wdata;
               CsrFrameHeight: fh_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         bx_ff     <= req_box_x;
         by_ff     <= req_box_y;
         bw_ff     <= req_box_w;
         bh_ff     <= req_box_h;
         last_ff   <= req_frame_last;
         area_a_ff <= req_box_w * req_box_h;
      end
      ix0_ff <= idx_ff[IdxW-1:0];
      // stage 1
      ix1_ff <= ix0_ff;
      ok1_ff <= s1_ok;
      o1_ff  <= s1_dx[CoordBits-1:0] * s1_dy[CoordBits-1:0];
      at1_ff <= rd_entry.w * rd_entry.h;
      id1_ff <= rd_entry.id;
      // stage 2
      ix2_ff <= ix1_ff;
      ok2_ff <= ok1_ff;
      o2_ff  <= o1_ff;
      u2_ff  <= {1'b0, area_a_ff} + {1'b0, at1_ff} - {1'b0, o1_ff};
      id2_ff <= id1_ff;
      // stage 3: keep the best candidate
      if (s3_take) begin
         best_ix_ff <= ix2_ff;
         best_id_ff <= id2_ff;
         best_o_ff  <= o2_ff;
         best_u_ff  <= u2_ff;
      end
      // result
      if (finish_go) begin
         r_id_ff     <= f_id;
         r_new_ff    <= !best_found_ff;
         r_vis_ff    <= f_vis;
         r_x_ff      <= f_vis ? bx_ff : '0;
         r_y_ff      <= f_vis ? by_ff : '0;
         r_w_ff      <= f_vis ? f_w : '0;
         r_h_ff      <= f_vis ? f_h : '0;
         r_stored_ff <= wr_en;
         r_last_ff   <= last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_track_id     = r_id_ff;
   assign rsp_is_new_track = r_new_ff;
   assign rsp_clip_x       = r_x_ff;
   assign rsp_clip_y       = r_y_ff;
   assign rsp_clip_w       = r_w_ff;
   assign rsp_clip_h       = r_h_ff;
   assign rsp_visible      = r_vis_ff;
   assign rsp_stored       = r_stored_ff;
   assign rsp_result_last  = r_last_ff;

endmodule

// ----- sv/iougbt_ram.sv -----
module iougbt_ram #(
   parameter int Width = 64,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- test/iou_greedy_box_tracker_tb.sv -----
module iou_greedy_box_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import iougbt_pkg::*;

   localparam int NumTracks = 16;

   // one box request as it goes on the wire
   typedef struct {
      bit                 has_box;
      bit [CoordBits-1:0] x;
      bit [CoordBits-1:0] y;
      bit [CoordBits-1:0] w;
      bit [CoordBits-1:0] h;
      bit                 last;
   } box_req_type;

   // one tracker result
   typedef struct {
      bit [IdBits-1:0]    id;
      bit                 fresh;
      bit [CoordBits-1:0] cx;
      bit [CoordBits-1:0] cy;
      bit [SizeBits-1:0]  cw;
      bit [SizeBits-1:0]  ch;
      bit                 vis;
      bit                 stored;
      bit                 last;
   } track_rsp_type;

   // track table entry
   typedef struct {
      bit                 valid;
      bit [IdBits-1:0]    id;
      bit [CoordBits-1:0] x;
      bit [CoordBits-1:0] y;
      bit [CoordBits-1:0] w;
      bit [CoordBits-1:0] h;
   } track_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_has_box = 1'b0;
   logic [CoordBits-1:0] req_box_x = '0;
   logic [CoordBits-1:0] req_box_y = '0;
   logic [CoordBits-1:0] req_box_w = '0;
   logic [CoordBits-1:0] req_box_h = '0;
   logic                 req_frame_last = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [IdBits-1:0]    rsp_track_id;
   logic                 rsp_is_new_track;
   logic [CoordBits-1:0] rsp_clip_x;
   logic [CoordBits-1:0] rsp_clip_y;
   logic [SizeBits-1:0]  rsp_clip_w;
   logic [SizeBits-1:0]  rsp_clip_h;
   logic                 rsp_visible;
   logic                 rsp_stored;
   logic                 rsp_result_last;
   logic                 csr_we = 1'b0;
   logic [1:0]           csr_addr = '0;
   logic [CsrBits-1:0]   csr_wdata = '0;

   iou_greedy_box_tracker #(.MAX_TRACKS(NumTracks)) uut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // tracker state mirrored by the testbench
   track_type       old_tracks[NumTracks];
   track_type       cur_tracks[NumTracks];
   bit [NumTracks-1:0] matched;
   int              cur_count;
   bit [IdBits-1:0] free_id;
   bit [ThrBits-1:0] thr_q8;
   bit [CsrBits-1:0] frame_w;
   bit [CsrBits-1:0] frame_h;

   box_req_type   pending[$];
   track_rsp_type expected_tracks[$];
   box_req_type   cur;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int errors = 0;
   int boxes_sent = 0;
   int frames_sent = 0;
   int results_seen = 0;
   int items_made = 0;

   // scene boxes reused between frames so that tracks match
   box_req_type scene[$];

   function automatic int umin(int a, int b);
      return (a < b) ? a : b;
   endfunction

   function automatic int umax(int a, int b);
      return (a > b) ? a : b;
   endfunction

   function automatic void close_frame();
      old_tracks = cur_tracks;
      foreach (cur_tracks[i]) cur_tracks[i].valid = 1'b0;
      matched = '0;
      cur_count = 0;
   endfunction

   // greedy IoU match of one accepted request
   function automatic void track_box(box_req_type r);
      track_rsp_type res;
      int best;
      longint unsigned best_o, best_u, o, u, area_a;
      bit [IdBits-1:0] best_id;
      int x1, y1, x2, y2;
      best = -1;
      best_o = 0;
      best_u = 1;
      best_id = '0;
      if (!r.has_box) begin
         if (r.last) close_frame();
         return;
      end
      area_a = longint'(r.w) * r.h;
      for (int i = 0; i < NumTracks; i++) begin
         if (!old_tracks[i].valid || matched[i]) continue;
         x1 = umax(r.x, old_tracks[i].x);
         y1 = umax(r.y, old_tracks[i].y);
         x2 = umin(r.x + r.w, old_tracks[i].x + old_tracks[i].w);
         y2 = umin(r.y + r.h, old_tracks[i].y + old_tracks[i].h);
         if (x2 <= x1 || y2 <= y1) continue;
         o = longint'(x2 - x1) * (y2 - y1);
         u = area_a + longint'(old_tracks[i].w) * old_tracks[i].h - o;
         if (o * 256 <= longint'(thr_q8) * u) continue;
         if (best < 0 || o * best_u > best_o * u ||
             (o * best_u == best_o * u && old_tracks[i].id < best_id)) begin
            best = i;
            best_o = o;
            best_u = u;
            best_id = old_tracks[i].id;
         end
      end
      if (best >= 0) begin
         res.id = best_id;
         res.fresh = 1'b0;
         matched[best] = 1'b1;
      end else begin
         res.id = free_id;
         res.fresh = 1'b1;
         free_id = (free_id == IdLast) ? IdFirst : free_id + 1'b1;
      end
      res.stored = 1'b0;
      if (cur_count < NumTracks) begin
         cur_tracks[cur_count] = '{1'b1, res.id, r.x, r.y, r.w, r.h};
         cur_count++;
         res.stored = 1'b1;
      end
      res.cx = '0;
      res.cy = '0;
      res.cw = '0;
      res.ch = '0;
      res.vis = 1'b0;
      if (r.w != 0 && r.h != 0 && r.x < frame_w && r.y < frame_h) begin
         res.cx = r.x;
         res.cy = r.y;
         res.cw = SizeBits'(umin(r.x + r.w, frame_w) - r.x);
         res.ch = SizeBits'(umin(r.y + r.h, frame_h) - r.y);
         res.vis = 1'b1;
      end
      res.last = r.last;
      expected_tracks = {expected_tracks, res};
      if (r.last) close_frame();
   endfunction

   // request driver
   always @(posedge clock) begin
      bit take;
      bit nv;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         take = req_valid && req_ready;
         if (take) begin
            track_box(cur);
            if (cur.has_box) boxes_sent++;
            if (cur.last) frames_sent++;
         end
         nv = req_valid && !take;
         if (!nv && pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            cur = pending.pop_front();
            req_has_box <= cur.has_box;
            req_box_x <= cur.x;
            req_box_y <= cur.y;
            req_box_w <= cur.w;
            req_box_h <= cur.h;
            req_frame_last <= cur.last;
            nv = 1'b1;
         end
         req_valid <= nv;
      end
   end

   // result monitor and back-pressure
   always @(posedge clock) begin
      track_rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_tracks.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual id=%0d",
                        $realtime, rsp_track_id);
            end else begin
               e = expected_tracks.pop_front();
               if (rsp_track_id !== e.id || rsp_is_new_track !== e.fresh ||
                   rsp_clip_x !== e.cx || rsp_clip_y !== e.cy ||
                   rsp_clip_w !== e.cw || rsp_clip_h !== e.ch ||
                   rsp_visible !== e.vis || rsp_stored !== e.stored ||
                   rsp_result_last !== e.last) begin
                  errors++;
                  $display("%0t: mismatch exp id=%0d new=%0b clip=%0d,%0d,%0d,%0d %s%0b %s%0b %s%0b",
                     $realtime, e.id, e.fresh, e.cx, e.cy, e.cw, e.ch,
                     "vis=", e.vis, "st=", e.stored, "last=", e.last);
                  $display("%0t: mismatch act id=%0d new=%0b clip=%0d,%0d,%0d,%0d %s%0b %s%0b %s%0b",
                     $realtime, rsp_track_id, rsp_is_new_track, rsp_clip_x,
                     rsp_clip_y, rsp_clip_w, rsp_clip_h, "vis=", rsp_visible,
                     "st=", rsp_stored, "last=", rsp_result_last);
               end
            end
         end
      end
   end

   task automatic add_req(bit hb, int x, int y, int w, int h, bit last);
      box_req_type r;
      r = '{hb, x[11:0], y[11:0], w[11:0], h[11:0], last};
      pending = {pending, r};
      items_made++;
   endtask

   // write all three registers while the tracker is idle
   task automatic set_regs(int thr, int fw, int fh);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= CsrThreshold;
      csr_wdata <= CsrBits'(thr);
      thr_q8 = ThrBits'(thr);
      @(posedge clock);
      csr_addr <= CsrFrameWidth;
      csr_wdata <= CsrBits'(fw);
      frame_w = CsrBits'(fw);
      @(posedge clock);
      csr_addr <= CsrFrameHeight;
      csr_wdata <= CsrBits'(fh);
      frame_h = CsrBits'(fh);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (pending.size() > 0 || req_valid || expected_tracks.size() > 0)
         @(posedge clock);
      // markers leave no result behind; cover a full box scan
      repeat (40) @(posedge clock);
   endtask

   function automatic box_req_type random_box(bit wide);
      box_req_type b;
      b.has_box = 1'b1;
      b.last = 1'b0;
      if (wide) begin
         b.x = CoordBits'($urandom_range(4095));
         b.y = CoordBits'($urandom_range(4095));
         b.w = CoordBits'($urandom_range(4095));
         b.h = CoordBits'($urandom_range(4095));
      end else begin
         b.x = CoordBits'($urandom_range(700));
         b.y = CoordBits'($urandom_range(500));
         b.w = CoordBits'($urandom_range(1, 120));
         b.h = CoordBits'($urandom_range(1, 120));
      end
      return b;
   endfunction

   // one frame: mostly jittered scene boxes, some fresh and some noise
   task automatic make_frame();
      int n;
      int k;
      bit marker_end;
      box_req_type b;
      n = ($urandom_range(7) == 0) ? $urandom_range(17, 20) : $urandom_range(0, 6);
      marker_end = (n == 0) || ($urandom_range(9) < 3);
      if ($urandom_range(30) == 0) scene.delete();
      for (int i = 0; i < n; i++) begin
         if (scene.size() > 0 && $urandom_range(9) < 7) begin
            k = $urandom_range(scene.size() - 1);
            b = scene[k];
            b.x = CoordBits'(b.x + $urandom_range(6) - 3);
            b.y = CoordBits'(b.y + $urandom_range(6) - 3);
            b.w = CoordBits'(b.w + $urandom_range(4) - 2);
            b.h = CoordBits'(b.h + $urandom_range(4) - 2);
            scene[k] = b;
         end else begin
            b = random_box($urandom_range(9) == 0);
            if (scene.size() < 24) scene = {scene, b};
         end
         if ($urandom_range(19) == 0) add_req(1'b0, $urandom, $urandom, $urandom, $urandom, 1'b0);
         add_req(1'b1, b.x, b.y, b.w, b.h, !marker_end && i == n - 1);
      end
      if (marker_end) add_req(1'b0, $urandom, $urandom, $urandom, $urandom, 1'b1);
   endtask

   task automatic random_phase(int sidle, int rstall, int count);
      int goal;
      send_idle_pct = sidle;
      recv_stall_pct = rstall;
      goal = items_made + count;
      while (items_made < goal) make_frame();
      drain();
   endtask

   initial begin
      foreach (old_tracks[i]) old_tracks[i].valid = 1'b0;
      foreach (cur_tracks[i]) cur_tracks[i].valid = 1'b0;
      matched = '0;
      cur_count = 0;
      free_id = IdFirst;
      thr_q8 = 8'd51;
      frame_w = 13'd1920;
      frame_h = 13'd1080;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: default registers, edge boxes and special cases
      add_req(1'b1, 100, 100, 50, 50, 1'b0);
      add_req(1'b1, 100, 100, 50, 50, 1'b0);
      add_req(1'b1, 0, 0, 0, 10, 1'b0);
      add_req(1'b1, 4095, 4095, 4095, 4095, 1'b0);
      add_req(1'b1, 1919, 1079, 10, 10, 1'b0);
      add_req(1'b1, 1920, 0, 10, 10, 1'b0);
      add_req(1'b0, 4095, 4095, 4095, 4095, 1'b0);
      add_req(1'b0, 0, 0, 0, 0, 1'b1);
      add_req(1'b1, 101, 101, 50, 50, 1'b0);
      add_req(1'b1, 100, 100, 50, 50, 1'b0);
      add_req(1'b1, 100, 100, 50, 50, 1'b0);
      add_req(1'b1, 0, 0, 4095, 4095, 1'b1);
      for (int i = 0; i < 18; i++) add_req(1'b1, 10 * i, 0, 8, 8, i == 17);
      drain();

      // threshold and frame extremes
      set_regs(0, 4096, 4096);
      add_req(1'b1, 0, 0, 4095, 4095, 1'b0);
      add_req(1'b1, 4094, 4094, 1, 1, 1'b1);
      add_req(1'b1, 4094, 4094, 1, 1, 1'b1);
      drain();
      set_regs(255, 0, 8191);
      add_req(1'b1, 4094, 4094, 1, 1, 1'b0);
      add_req(1'b1, 0, 0, 5, 5, 1'b1);
      drain();

      random_phase(0, 0, 300);
      set_regs(128, 640, 480);
      random_phase(83, 0, 250);
      set_regs(255, 1, 1);
      random_phase(0, 83, 250);
      set_regs(51, 1920, 1080);
      random_phase(18, 18, 300);
      set_regs(20, 4096, 4096);
      random_phase(0, 0, 250);

      $display("Tracked %0d boxes over %0d frames, %0d results checked.",
               boxes_sent, frames_sent, results_seen);
      $display("Covered full tables, empty frames, clipping edges and idle/stall phases.");
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // run-time limit
   initial begin
      #15ms;
      $display("FAILURE");
      $finish;
   end

endmodule
